FILE: rtl/core/dmpc_pkg.sv
`timescale 1ns / 1ps

package dmpc_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;

  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CDIM_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RDIM_W  = $clog2(MAX_ROWS + 1);
  localparam int DEPTH   = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int PIX_W   = 24;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 17;
  localparam int NUM_W   = 34;          // |centre +- radius - origin|
  localparam int QUO_W   = NUM_W + 1;   // signed quotient
  localparam int DVS_W   = 17;          // pixel size (or 1) and pixel count
  localparam int DCNT_W  = $clog2(NUM_W);
  localparam int DX_W    = 40;          // grid offset from centre, signed

  // config register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_PIX_SIZE = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;

  typedef enum logic [2:0] {
    SEL_CLO,
    SEL_CHI,
    SEL_RLO,
    SEL_RHI,
    SEL_RED,
    SEL_GRN,
    SEL_BLU
  } div_sel_e;

  typedef struct packed {
    logic     px_write;
    logic     query_load;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     box_init;
    logic     px_dist;
    logic     px_test;
    logic     px_acc;
    logic     step_row;
    logic     next_col;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic box_empty;
    logic row_last;
    logic col_last;
    logic count_zero;
  } status_t;

endpackage

FILE: rtl/core/dmpc_ram.sv
`timescale 1ns / 1ps

module dmpc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/dmpc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Sign applied at the end.
module dmpc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              neg_i,
  input  logic [dmpc_pkg::NUM_W-1:0]        dividend_i,
  input  logic [dmpc_pkg::DVS_W-1:0]        divisor_i,
  output logic                              done_o,
  output logic signed [dmpc_pkg::QUO_W-1:0] quotient_o
);

  logic                             busy_q;
  logic                             done_q;
  logic                             neg_q;
  logic [dmpc_pkg::DCNT_W-1:0]      cnt_q;
  logic [dmpc_pkg::NUM_W-1:0]       quo_q;
  logic [dmpc_pkg::DVS_W-1:0]       rem_q;
  logic [dmpc_pkg::DVS_W-1:0]       dvs_q;
  logic [dmpc_pkg::DVS_W:0]         trial;
  logic [dmpc_pkg::DVS_W:0]         diff;
  logic                             fits;
  logic                             last_step;
  logic signed [dmpc_pkg::QUO_W-1:0] mag;

  assign trial     = {rem_q, quo_q[dmpc_pkg::NUM_W-1]};
  assign diff      = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};
  assign last_step = (cnt_q == dmpc_pkg::DCNT_W'(dmpc_pkg::NUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[dmpc_pkg::DVS_W-1:0] : trial[dmpc_pkg::DVS_W-1:0];
      quo_q <= {quo_q[dmpc_pkg::NUM_W-2:0], fits};
    end
  end

  assign mag        = $signed({1'b0, quo_q});
  assign quotient_o = neg_q ? -mag : mag;
  assign done_o     = done_q;

endmodule

FILE: rtl/core/dmpc_datapath.sv
`timescale 1ns / 1ps

module dmpc_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dmpc_pkg::cmd_t         cmd_i,
  output dmpc_pkg::status_t      status_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic [7:0]             pixel_column_i,
  input  logic [7:0]             pixel_row_i,
  input  logic [7:0]             red_in_i,
  input  logic [7:0]             green_in_i,
  input  logic [7:0]             blue_in_i,
  input  logic signed [31:0]     centre_x_i,
  input  logic signed [31:0]     centre_y_i,
  input  logic [15:0]            disc_radius_i,
  output logic [7:0]             mean_red_o,
  output logic [7:0]             mean_green_o,
  output logic [7:0]             mean_blue_o,
  output logic [16:0]            pixel_count_o,
  output logic                   empty_disc_o
);

  localparam int NW = dmpc_pkg::NUM_W;
  localparam int QW = dmpc_pkg::QUO_W;
  localparam int DW = dmpc_pkg::DX_W;
  localparam int CW = dmpc_pkg::COL_W;
  localparam int RW = dmpc_pkg::ROW_W;
  localparam int AW = dmpc_pkg::ADDR_W;

  // configuration
  logic signed [31:0] ox_q, oy_q;
  logic [15:0]        ps_q;
  logic [8:0]         iw_q, ih_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0;
      oy_q <= '0;
      ps_q <= 16'd256;
      iw_q <= 9'd256;
      ih_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dmpc_pkg::REG_ORIGIN_X: ox_q <= $signed(cfg_data_i);
        dmpc_pkg::REG_ORIGIN_Y: oy_q <= $signed(cfg_data_i);
        dmpc_pkg::REG_PIX_SIZE: ps_q <= cfg_data_i[15:0];
        dmpc_pkg::REG_WIDTH:    iw_q <= cfg_data_i[8:0];
        dmpc_pkg::REG_HEIGHT:   ih_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic [dmpc_pkg::DVS_W-1:0]  ps_eff;
  logic [dmpc_pkg::CDIM_W-1:0] w_use;
  logic [dmpc_pkg::RDIM_W-1:0] h_use;

  assign ps_eff = (ps_q == 16'd0) ? dmpc_pkg::DVS_W'(1) : {1'b0, ps_q};
  assign w_use  = (32'(iw_q) > 32'(dmpc_pkg::MAX_COLUMNS)) ?
                  dmpc_pkg::CDIM_W'(dmpc_pkg::MAX_COLUMNS) : dmpc_pkg::CDIM_W'(iw_q);
  assign h_use  = (32'(ih_q) > 32'(dmpc_pkg::MAX_ROWS)) ?
                  dmpc_pkg::RDIM_W'(dmpc_pkg::MAX_ROWS) : dmpc_pkg::RDIM_W'(ih_q);

  // image store
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [dmpc_pkg::PIX_W-1:0] ram_rdata;

  assign ram_we    = cmd_i.px_write &&
                     (32'(pixel_column_i) < 32'(w_use)) && (32'(pixel_row_i) < 32'(h_use));
  assign ram_waddr = AW'(32'(pixel_column_i) + 32'(pixel_row_i) * 32'(w_use));

  // query
  logic signed [31:0] cx_q, cy_q;
  logic [15:0]        r_q;
  logic [31:0]        r2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_load) begin
      cx_q <= centre_x_i;
      cy_q <= centre_y_i;
      r_q  <= disc_radius_i;
    end
  end

  // divider operands
  logic signed [NW-1:0] rad_s, num;
  logic                 div_neg, div_done;
  logic [NW-1:0]        div_mag;
  logic [dmpc_pkg::DVS_W-1:0] div_dvs;
  logic signed [QW-1:0] div_quo;
  logic [dmpc_pkg::SUM_W-1:0] red_sum_q, grn_sum_q, blu_sum_q;
  logic [dmpc_pkg::CNT_W-1:0] count_q;

  assign rad_s = NW'($signed({1'b0, r_q}));

  always_comb begin
    num     = '0;
    div_dvs = ps_eff;
    unique case (cmd_i.div_sel)
      dmpc_pkg::SEL_CLO: num = NW'(cx_q) - rad_s - NW'(ox_q);
      dmpc_pkg::SEL_CHI: num = NW'(cx_q) + rad_s - NW'(ox_q);
      dmpc_pkg::SEL_RLO: num = NW'(cy_q) - rad_s - NW'(oy_q);
      dmpc_pkg::SEL_RHI: num = NW'(cy_q) + rad_s - NW'(oy_q);
      dmpc_pkg::SEL_RED: begin
        num     = $signed(NW'(red_sum_q));
        div_dvs = count_q;
      end
      dmpc_pkg::SEL_GRN: begin
        num     = $signed(NW'(grn_sum_q));
        div_dvs = count_q;
      end
      dmpc_pkg::SEL_BLU: begin
        num     = $signed(NW'(blu_sum_q));
        div_dvs = count_q;
      end
      default: ;
    endcase
  end

  assign div_neg = num[NW-1];
  assign div_mag = div_neg ? NW'(-num) : NW'(num);

  dmpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .neg_i      (div_neg),
    .dividend_i (div_mag),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // pixel box
  logic signed [QW-1:0] clo_q, chi_q, rlo_q, rhi_q;
  logic signed [QW-1:0] clo_cl, chi_cl, rlo_cl, rhi_cl, wm1, hm1;
  logic [7:0]           mred_q, mgrn_q, mblu_q;

  assign wm1    = QW'($signed({1'b0, w_use})) - QW'(1);
  assign hm1    = QW'($signed({1'b0, h_use})) - QW'(1);
  assign clo_cl = (clo_q < 0) ? '0 : clo_q;
  assign rlo_cl = (rlo_q < 0) ? '0 : rlo_q;
  assign chi_cl = (chi_q > wm1) ? wm1 : chi_q;
  assign rhi_cl = (rhi_q > hm1) ? hm1 : rhi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      unique case (cmd_i.div_sel)
        dmpc_pkg::SEL_CLO: clo_q  <= div_quo;
        dmpc_pkg::SEL_CHI: chi_q  <= div_quo;
        dmpc_pkg::SEL_RLO: rlo_q  <= div_quo;
        dmpc_pkg::SEL_RHI: rhi_q  <= div_quo;
        dmpc_pkg::SEL_RED: mred_q <= div_quo[7:0];
        dmpc_pkg::SEL_GRN: mgrn_q <= div_quo[7:0];
        dmpc_pkg::SEL_BLU: mblu_q <= div_quo[7:0];
        default: ;
      endcase
    end else if (cmd_i.box_init) begin
      mred_q <= '0;
      mgrn_q <= '0;
      mblu_q <= '0;
    end
  end

  // scan
  logic [CW-1:0]        ci_q, chi_cl_q;
  logic [RW-1:0]        rj_q, rlo_cl_q, rhi_cl_q;
  logic signed [DW-1:0] dx, dy, dx_q, dy_q, rad_w;
  logic                 dx_in_q, dy_in_q, hit_q;
  logic [15:0]          adx, ady;
  logic [32:0]          d2;

  assign rad_w = DW'($signed({1'b0, r_q}));
  assign dx    = $signed(DW'(32'(ci_q) * 32'(ps_eff))) + DW'(ox_q) - DW'(cx_q);
  assign dy    = $signed(DW'(32'(rj_q) * 32'(ps_eff))) + DW'(oy_q) - DW'(cy_q);
  assign adx   = dx_q[DW-1] ? 16'(-dx_q) : dx_q[15:0];
  assign ady   = dy_q[DW-1] ? 16'(-dy_q) : dy_q[15:0];
  assign d2    = 33'(32'(adx) * 32'(adx)) + 33'(32'(ady) * 32'(ady));
  assign ram_raddr = AW'(32'(ci_q) + 32'(rj_q) * 32'(w_use));

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_init) begin
      ci_q     <= clo_cl[CW-1:0];
      chi_cl_q <= chi_cl[CW-1:0];
      rj_q     <= rlo_cl[RW-1:0];
      rlo_cl_q <= rlo_cl[RW-1:0];
      rhi_cl_q <= rhi_cl[RW-1:0];
      r2_q     <= 32'(r_q) * 32'(r_q);
    end else if (cmd_i.step_row) begin
      rj_q <= rj_q + 1'b1;
    end else if (cmd_i.next_col) begin
      ci_q <= ci_q + 1'b1;
      rj_q <= rlo_cl_q;
    end
    if (cmd_i.px_dist) begin
      dx_q    <= dx;
      dy_q    <= dy;
      dx_in_q <= (dx <= rad_w) && (dx >= -rad_w);
      dy_in_q <= (dy <= rad_w) && (dy >= -rad_w);
    end
    if (cmd_i.px_test) begin
      hit_q <= dx_in_q && dy_in_q && (d2 <= {1'b0, r2_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_sum_q <= '0;
      grn_sum_q <= '0;
      blu_sum_q <= '0;
      count_q   <= '0;
    end else if (cmd_i.box_init) begin
      red_sum_q <= '0;
      grn_sum_q <= '0;
      blu_sum_q <= '0;
      count_q   <= '0;
    end else if (cmd_i.px_acc && hit_q) begin
      red_sum_q <= red_sum_q + dmpc_pkg::SUM_W'(ram_rdata[23:16]);
      grn_sum_q <= grn_sum_q + dmpc_pkg::SUM_W'(ram_rdata[15:8]);
      blu_sum_q <= blu_sum_q + dmpc_pkg::SUM_W'(ram_rdata[7:0]);
      count_q   <= count_q + 1'b1;
    end
  end

  dmpc_ram #(
    .WIDTH (dmpc_pkg::PIX_W),
    .DEPTH (dmpc_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .re_i    (cmd_i.px_test),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_red_o    <= mred_q;
      mean_green_o  <= mgrn_q;
      mean_blue_o   <= mblu_q;
      pixel_count_o <= count_q;
      empty_disc_o  <= (count_q == '0);
    end
  end

  assign status_o.div_done   = div_done;
  assign status_o.box_empty  = (chi_cl < clo_cl) || (rhi_cl < rlo_cl);
  assign status_o.row_last   = (rj_q == rhi_cl_q);
  assign status_o.col_last   = (ci_q == chi_cl_q);
  assign status_o.count_zero = (count_q == '0);

endmodule

FILE: rtl/core/dmpc_ctrl.sv
`timescale 1ns / 1ps

module dmpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  dmpc_pkg::status_t status_i,
  output dmpc_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_BOX,
    ST_DIST,
    ST_TEST,
    ST_ACC,
    ST_MEAN
  } state_e;

  state_e              state_q;
  dmpc_pkg::div_sel_e  sel_q;
  logic                out_valid_q;
  logic                fin_q;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // fin_q: a finished result waits for the output register
  assign in_stall_o = (state_q != ST_IDLE) || fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= dmpc_pkg::SEL_CLO;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      if (fin_q && out_free) begin
        fin_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && kind_i) begin
            sel_q   <= dmpc_pkg::SEL_CLO;
            state_q <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (status_i.div_done) begin
            unique case (sel_q)
              dmpc_pkg::SEL_CLO: begin
                sel_q   <= dmpc_pkg::SEL_CHI;
                state_q <= ST_DIV_GO;
              end
              dmpc_pkg::SEL_CHI: begin
                sel_q   <= dmpc_pkg::SEL_RLO;
                state_q <= ST_DIV_GO;
              end
              dmpc_pkg::SEL_RLO: begin
                sel_q   <= dmpc_pkg::SEL_RHI;
                state_q <= ST_DIV_GO;
              end
              dmpc_pkg::SEL_RHI: state_q <= ST_BOX;
              dmpc_pkg::SEL_RED: begin
                sel_q   <= dmpc_pkg::SEL_GRN;
                state_q <= ST_DIV_GO;
              end
              dmpc_pkg::SEL_GRN: begin
                sel_q   <= dmpc_pkg::SEL_BLU;
                state_q <= ST_DIV_GO;
              end
              dmpc_pkg::SEL_BLU: begin
                fin_q   <= 1'b1;
                state_q <= ST_IDLE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_BOX: begin
          if (status_i.box_empty) begin
            fin_q   <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_DIST;
          end
        end
        ST_DIST: state_q <= ST_TEST;
        ST_TEST: state_q <= ST_ACC;
        ST_ACC: begin
          if (status_i.row_last && status_i.col_last) begin
            state_q <= ST_MEAN;
          end else begin
            state_q <= ST_DIST;
          end
        end
        ST_MEAN: begin
          if (status_i.count_zero) begin
            fin_q   <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            sel_q   <= dmpc_pkg::SEL_RED;
            state_q <= ST_DIV_GO;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.div_sel    = sel_q;
    cmd_o.px_write   = accept && !kind_i;
    cmd_o.query_load = accept && kind_i;
    cmd_o.out_load   = fin_q && out_free;
    unique case (state_q)
      ST_DIV_GO:   cmd_o.div_start = 1'b1;
      ST_DIV_WAIT: cmd_o.div_store = status_i.div_done;
      ST_BOX:      cmd_o.box_init  = 1'b1;
      ST_DIST:     cmd_o.px_dist   = 1'b1;
      ST_TEST:     cmd_o.px_test   = 1'b1;
      ST_ACC: begin
        cmd_o.px_acc   = 1'b1;
        cmd_o.step_row = !status_i.row_last;
        cmd_o.next_col = status_i.row_last && !status_i.col_last;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/disc_mean_pixel_colour.sv
`timescale 1ns / 1ps

// Disc mean colour over a stored RGB image. A beat with kind 0 writes one
// pixel at column + row * width if it lies inside the image. A beat with
// kind 1 asks for the mean colour of the pixels whose grid points lie
// within the disc. A query runs four divisions for the pixel box (one
// shared radix-2 divider, 34 steps per division), then visits each pixel
// of the clipped box (distance, square test with store read, accumulate),
// then runs three divisions for the channel means when any pixel was hit.
// Input stalls while a query is under way; a finished result sits in the
// output register so the next beat can be taken.
// Config writes go through at any time but are meant for idle periods.
// Pixels never written read back undefined.
module disc_mean_pixel_colour (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beats
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [7:0]         pixel_column_i,
  input  logic [7:0]         pixel_row_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  input  logic signed [31:0] centre_x_i,
  input  logic signed [31:0] centre_y_i,
  input  logic [15:0]        disc_radius_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         mean_red_o,
  output logic [7:0]         mean_green_o,
  output logic [7:0]         mean_blue_o,
  output logic [16:0]        pixel_count_o,
  output logic               empty_disc_o,
  // config writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  dmpc_pkg::cmd_t    cmd;
  dmpc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  dmpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dmpc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .centre_x_i     (centre_x_i),
    .centre_y_i     (centre_y_i),
    .disc_radius_i  (disc_radius_i),
    .mean_red_o     (mean_red_o),
    .mean_green_o   (mean_green_o),
    .mean_blue_o    (mean_blue_o),
    .pixel_count_o  (pixel_count_o),
    .empty_disc_o   (empty_disc_o)
  );

endmodule

FILE: bench/disc_mean_pixel_colour_tb.sv
`timescale 1ns / 1ps

module disc_mean_pixel_colour_tb;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] count;
    logic        empty;
  } disc_mean_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // block ports, all inputs driven from time zero
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               kind_i = 1'b0;
  logic [7:0]         pixel_column_i = '0;
  logic [7:0]         pixel_row_i = '0;
  logic [7:0]         red_in_i = '0;
  logic [7:0]         green_in_i = '0;
  logic [7:0]         blue_in_i = '0;
  logic signed [31:0] centre_x_i = '0;
  logic signed [31:0] centre_y_i = '0;
  logic [15:0]        disc_radius_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic [7:0]         mean_red_o;
  logic [7:0]         mean_green_o;
  logic [7:0]         mean_blue_o;
  logic [16:0]        pixel_count_o;
  logic               empty_disc_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  disc_mean_pixel_colour dut (.*);

  // shadow copy of the block: image memory and registers
  logic [23:0] pix_mem [0:65535];
  longint      sh_origin_x, sh_origin_y;
  int          sh_pix_size, sh_width, sh_height;

  disc_mean_t  mean_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          queries_sent = 0;
  int          pixels_sent = 0;
  int          cfg_writes = 0;

  // pacing controls
  bit          quiet = 1'b0;      // no idling on either side
  bit          hold_req = 1'b0;   // ask receiver for a long hold-off

  function automatic int cols_used();
    return (sh_width > dmpc_pkg::MAX_COLUMNS) ? dmpc_pkg::MAX_COLUMNS : sh_width;
  endfunction

  function automatic int rows_used();
    return (sh_height > dmpc_pkg::MAX_ROWS) ? dmpc_pkg::MAX_ROWS : sh_height;
  endfunction

  function automatic longint step_size();
    return (sh_pix_size == 0) ? 64'sd1 : longint'(sh_pix_size);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Expected disc mean: walk the clipped box, keep grid points within the radius.
  function automatic disc_mean_t disc_mean(logic signed [31:0] cx_in,
                                           logic signed [31:0] cy_in,
                                           logic [15:0] rad_in);
    longint         cx, cy, r, ps, clo, chi, rlo, rhi, dx, dy, i, j;
    longint unsigned r2, d2;
    int             w, h;
    logic [23:0]    rs, gs, bs, px;
    logic [16:0]    n;
    disc_mean_t     m;
    w  = cols_used();
    h  = rows_used();
    cx = longint'(cx_in);
    cy = longint'(cy_in);
    r  = longint'(rad_in);
    ps = step_size();
    clo = (cx - r - sh_origin_x) / ps;
    chi = (cx + r - sh_origin_x) / ps;
    rlo = (cy - r - sh_origin_y) / ps;
    rhi = (cy + r - sh_origin_y) / ps;
    r2 = r * r;
    rs = '0; gs = '0; bs = '0; n = '0;
    if (clo < 0) clo = 0;
    if (rlo < 0) rlo = 0;
    if (chi > w - 1) chi = w - 1;
    if (rhi > h - 1) rhi = h - 1;
    for (i = clo; i <= chi; i++) begin
      dx = i * ps + sh_origin_x - cx;
      if (dx > r || dx < -r) continue;
      for (j = rlo; j <= rhi; j++) begin
        dy = j * ps + sh_origin_y - cy;
        if (dy > r || dy < -r) continue;
        d2 = dx * dx + dy * dy;
        if (d2 > r2) continue;
        px = pix_mem[16'(i + j * w)];
        rs += 24'(px[23:16]);
        gs += 24'(px[15:8]);
        bs += 24'(px[7:0]);
        n  += 17'd1;
      end
    end
    m = '0;
    if (n == 0) begin
      m.empty = 1'b1;
    end else begin
      m.red   = 8'(rs / {7'd0, n});
      m.green = 8'(gs / {7'd0, n});
      m.blue  = 8'(bs / {7'd0, n});
      m.count = n;
    end
    return m;
  endfunction

  // One input beat. Valid goes high at a falling edge and stays until taken.
  task automatic send_beat(logic kind, logic [7:0] col, logic [7:0] row,
                           logic [23:0] rgb, logic signed [31:0] cx,
                           logic signed [31:0] cy, logic [15:0] rad);
    int gap;
    if (!quiet && $urandom_range(99) < 37) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    pixel_column_i <= col;
    pixel_row_i    <= row;
    red_in_i       <= rgb[23:16];
    green_in_i     <= rgb[15:8];
    blue_in_i      <= rgb[7:0];
    centre_x_i     <= cx;
    centre_y_i     <= cy;
    disc_radius_i  <= rad;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == 1'b0) begin
      pixels_sent++;
      if (col < cols_used() && row < rows_used())
        pix_mem[16'(col + row * cols_used())] = rgb;
    end else begin
      queries_sent++;
      mean_q.push_back(disc_mean(cx, cy, rad));
    end
  endtask

  task automatic send_pixel(int col, int row, logic [23:0] rgb);
    send_beat(1'b0, col[7:0], row[7:0], rgb, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic send_query(logic signed [31:0] cx, logic signed [31:0] cy,
                            logic [15:0] rad);
    send_beat(1'b1, 8'($urandom), 8'($urandom), 24'($urandom), cx, cy, rad);
  endtask

  // Query near the image: centre between two grid points before the origin
  // corner and span + 1 after it, radius up to reach pixels.
  task automatic near_query(int reach, int span);
    longint ps, cx, cy, rad;
    ps = step_size();
    cx = sh_origin_x + (longint'($urandom_range(span + 3)) - 2) * ps;
    cy = sh_origin_y + (longint'($urandom_range(span + 3)) - 2) * ps;
    if ($urandom_range(7) == 0) begin
      rad = longint'($urandom_range(reach)) * ps;   // grid points right on the rim
    end else begin
      cx += (longint'($urandom_range(32'(2 * ps))) - ps) / 2;
      cy += (longint'($urandom_range(32'(2 * ps))) - ps) / 2;
      rad = longint'($urandom_range(32'(reach * ps)));
    end
    if (rad > 65535) rad = 65535;
    send_query(clamp32(cx), clamp32(cy), rad[15:0]);
  endtask

  // Drop valid, wait for every result, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      dmpc_pkg::REG_ORIGIN_X: sh_origin_x = longint'(signed'(data));
      dmpc_pkg::REG_ORIGIN_Y: sh_origin_y = longint'(signed'(data));
      dmpc_pkg::REG_PIX_SIZE: sh_pix_size = int'(data[15:0]);
      dmpc_pkg::REG_WIDTH:    sh_width    = int'(data[8:0]);
      dmpc_pkg::REG_HEIGHT:   sh_height   = int'(data[8:0]);
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [31:0] ox, logic [31:0] oy, int ps, int w, int h);
    drain();
    write_reg(dmpc_pkg::REG_ORIGIN_X, ox);
    write_reg(dmpc_pkg::REG_ORIGIN_Y, oy);
    write_reg(dmpc_pkg::REG_PIX_SIZE, ps);
    write_reg(dmpc_pkg::REG_WIDTH, w);
    write_reg(dmpc_pkg::REG_HEIGHT, h);
  endtask

  // Write a rectangle of pixels so queries touching it read known data.
  task automatic fill_patch(int c0, int r0, int nc, int nr);
    for (int j = r0; j < r0 + nr; j++)
      for (int i = c0; i < c0 + nc; i++)
        send_pixel(i, j, 24'($urandom));
  endtask

  // Every address in use gets written before any query can read it.
  task automatic fill_image();
    fill_patch(0, 0, cols_used(), rows_used());
  endtask

  // ---- tests ----

  // Reset geometry: full 256 x 256 image, pixel size 256, origin zero.
  // Only the two corner patches are written and queries stay inside them.
  task automatic test_reset_geometry();
    fill_patch(0, 0, 8, 8);
    fill_patch(252, 252, 4, 4);
    send_query(32'sd1280, 32'sd1280, 16'd0);          // lone grid point
    send_query(32'sd1280, 32'sd1280, 16'd256);        // four neighbors on the rim
    send_query(32'sd1408, 32'sd1408, 16'd0);          // between grid points: empty
    send_query(32'sd0, 32'sd0, 16'd300);              // corner, clipped box
    send_query(32'sd65280, 32'sd65280, 16'd700);      // far corner
    send_query(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hFFFF);
    send_query(32'sh80000000, 32'sh80000000, 16'hFFFF);
    send_query(32'sh80000000, 32'sd1000, 16'd5000);
    send_query(-32'sd300, 32'sd512, 16'd300);         // centre left of image
    send_pixel(3, 4, 24'hFFFFFF);
    send_query(32'sd768, 32'sd1024, 16'd0);           // read back fresh write
    send_pixel(3, 4, 24'h000000);
    send_query(32'sd768, 32'sd1024, 16'd0);
    send_pixel(255, 255, 24'hA5C35A);
    send_query(32'sd65280, 32'sd65280, 16'd0);
    send_query(32'sd1024, 32'sd1024, 16'd640);        // wider disc inside the patch
    drain();
  endtask

  // Register extremes; size stays 256 x 256 via saturation, queries stay in the
  // corner patch written above.
  task automatic test_register_extremes();
    set_geometry(32'h80000000, 32'h7FFFFFFF, 65535, 511, 300);
    repeat (6) near_query(3, 4);
    send_query(32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF);
    send_query(32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
    set_geometry(32'sd0, 32'sd0, 0, 256, 256);         // zero size acts as one
    repeat (6) near_query(4, 1);
    set_geometry(32'sd77, -32'sd33, 1, 256, 256);
    repeat (6) near_query(4, 1);
    drain();
  endtask

  // Small images, with writes outside the image that must be ignored.
  task automatic test_small_image();
    set_geometry(-32'sd1000, 32'sd2500, 100, 8, 6);
    fill_image();
    repeat (12) send_pixel($urandom_range(255), $urandom_range(255), 24'($urandom));
    repeat (10) near_query(5, cols_used());
    send_query($urandom, $urandom, 16'hFFFF);
    set_geometry(32'sd0, 32'sd0, 256, 1, 1);
    fill_image();
    send_pixel(1, 0, 24'($urandom));
    send_pixel(0, 1, 24'($urandom));
    send_query(32'sd0, 32'sd0, 16'd0);
    send_query(32'sd100, 32'sd0, 16'd99);
    send_query(32'sd100, 32'sd0, 16'd100);
    drain();
  endtask

  // Receiver holds off while queries pile up behind the result register.
  task automatic test_hold_off();
    set_geometry(32'sd0, 32'sd0, 64, 6, 6);
    fill_image();
    drain();
    hold_req = 1'b1;
    repeat (8) near_query(2, cols_used());
    drain();
  endtask

  // Random geometries, each filled, then mixed writes and queries.
  task automatic test_random_mix();
    int w, h, ps;
    logic [31:0] ox, oy;
    for (int round = 0; round < 8; round++) begin
      w  = $urandom_range(1, 8);
      h  = $urandom_range(1, 8);
      case ($urandom_range(3))
        0:       ps = $urandom_range(1, 8);
        1:       ps = $urandom_range(60000, 65535);
        default: ps = $urandom_range(16, 1024);
      endcase
      ox = ($urandom_range(3) == 0) ? $urandom : 32'(int'($urandom_range(2000000)) - 1000000);
      oy = ($urandom_range(3) == 0) ? $urandom : 32'(int'($urandom_range(2000000)) - 1000000);
      set_geometry(ox, oy, ps, w, h);
      fill_image();
      quiet = (round == 3);   // one stretch at full rate
      for (int k = 0; k < 30; k++) begin
        case ($urandom_range(7))
          0, 1:    send_pixel($urandom_range(w + 2), $urandom_range(h + 2), 24'($urandom));
          2:       send_query($urandom, $urandom, 16'($urandom));
          default: near_query(4, cols_used());
        endcase
      end
      drain();
      quiet = 1'b0;
    end
  endtask

  // ---- receiver pacing, with a counted hold-off ----
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 2000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 37);
    end
  end

  // ---- result checker ----
  always @(posedge clk_i) begin
    disc_mean_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (mean_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: r %0d g %0d b %0d n %0d e %0b",
                   mean_red_o, mean_green_o, mean_blue_o, pixel_count_o, empty_disc_o);
      end else begin
        want = mean_q.pop_front();
        if (mean_red_o !== want.red || mean_green_o !== want.green ||
            mean_blue_o !== want.blue || pixel_count_o !== want.count ||
            empty_disc_o !== want.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mean mismatch: exp r %0d g %0d b %0d n %0d e %0b, got r %0d g %0d b %0d n %0d e %0b",
                     want.red, want.green, want.blue, want.count, want.empty,
                     mean_red_o, mean_green_o, mean_blue_o, pixel_count_o, empty_disc_o);
        end
      end
    end
  end

  // ---- sequence ----
  initial begin
    sh_origin_x = 0;
    sh_origin_y = 0;
    sh_pix_size = 256;
    sh_width    = 256;
    sh_height   = 256;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (5) @(posedge clk_i);
    test_reset_geometry();
    test_register_extremes();
    test_small_image();
    test_hold_off();
    test_random_mix();
    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d pixel writes, %0d disc queries, %0d register writes",
             pixels_sent, queries_sent, cfg_writes);
    $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && mean_q.size() == 0) begin
      $display("disc_mean_pixel_colour_tb: clean");
    end else begin
      $display("disc_mean_pixel_colour_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("timeout with %0d results outstanding", mean_q.size());
    $display("disc_mean_pixel_colour_tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/dmpc_pkg.sv
rtl/core/dmpc_ram.sv
rtl/core/dmpc_div.sv
rtl/core/dmpc_datapath.sv
rtl/core/dmpc_ctrl.sv
rtl/core/disc_mean_pixel_colour.sv
bench/disc_mean_pixel_colour_tb.sv
